// ===== rtl/keq_pkg.sv =====
// Shared types and constants for the key event queue with auto release.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package keq_pkg;

  localparam int unsigned CodeWidth    = 8;
  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned TimeoutWidth = 16;
  localparam int unsigned EventWidth   = CodeWidth + 1;

  localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd250;

  localparam logic CmdArrive = 1'b0;
  localparam logic CmdGet    = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [CodeWidth-1:0] key_code;
    logic [TimeWidth-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                 has_event;
    logic                 is_press;
    logic [CodeWidth-1:0] event_key;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic arrive;
    logic scan_step;
    logic pop_read;
    logic pop_emit;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

// ===== rtl/key_event_queue_auto_release_unit.sv =====
// Top level of the key event queue with auto release after an idle timeout.
// Instantiates keq_controller and keq_datapath; depends on keq_pkg.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low. A key arrival keeps busy
// high for one cycle and gives no result. A get request scans every key through
// the single read port of the last-seen memory, one key per cycle, while busy
// stays high; the result word then sits on result in the cycle after busy falls,
// with done high. The receiver cannot stall: a result is taken in the cycle it
// appears. A new word may be started in that same cycle.
// The timeout register is written through cfg_valid/cfg_data and is always
// ready; write it only while the block is idle.
module key_event_queue_auto_release_unit #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned KEY_COUNT   = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  keq_pkg::in_item_t                request,
  output logic                             done,
  output keq_pkg::out_item_t               result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [keq_pkg::TimeoutWidth-1:0] cfg_data
);

  keq_pkg::ctrl_t   ctrl;
  keq_pkg::status_t status;

  assign cfg_ready = 1'b1;

  keq_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (request.cmd),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  keq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_COUNT   (KEY_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .ctrl     (ctrl),
    .status   (status),
    .result   (result),
    .done     (done)
  );

  // A result appears only once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_arrive_len: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.cmd == keq_pkg::CmdArrive)) |=> busy ##1 !busy)
    else $error("key arrival did not take exactly one busy cycle");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.has_event) |-> (!result.is_press && (result.event_key == '0)))
    else $error("empty result carries nonzero fields");

endmodule

// ===== rtl/keq_controller.sv =====
// Sequencer for the key event queue: arrival, key scan and pop.
// Depends on keq_pkg for the command and status structs.
`timescale 1ns / 1ps

module keq_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            cmd,
  input  keq_pkg::status_t status,
  output keq_pkg::ctrl_t   ctrl,
  output logic            busy
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StArrive = 3'd1;
  localparam logic [2:0] StScan   = 3'd2;
  localparam logic [2:0] StTail   = 3'd3;
  localparam logic [2:0] StPopRd  = 3'd4;
  localparam logic [2:0] StPop    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      StIdle: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = (cmd == keq_pkg::CmdGet) ? StScan : StArrive;
        end
      end
      StArrive: begin
        ctrl.arrive = 1'b1;
        state_next  = StIdle;
      end
      StScan: begin
        ctrl.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = StTail;
        end
      end
      // The last key is evaluated here, in the cycle after its memory read.
      StTail: begin
        state_next = StPopRd;
      end
      StPopRd: begin
        ctrl.pop_read = 1'b1;
        state_next    = StPop;
      end
      StPop: begin
        ctrl.pop_emit = 1'b1;
        state_next    = StIdle;
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  assign busy = (state != StIdle);

endmodule

// ===== rtl/keq_datapath.sv =====
// Datapath: request register, timeout register, last-seen memory, held flags,
// event ring memory and result register. Depends on keq_pkg.
`timescale 1ns / 1ps

module keq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned KEY_COUNT   = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  keq_pkg::in_item_t                   request,
  input  logic                                cfg_we,
  input  logic [keq_pkg::TimeoutWidth-1:0]    cfg_data,
  input  keq_pkg::ctrl_t                      ctrl,
  output keq_pkg::status_t                    status,
  output keq_pkg::out_item_t                  result,
  output logic                                done
);

  localparam int unsigned KW = $clog2(KEY_COUNT);
  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam logic [keq_pkg::CodeWidth:0] KeyLimit = (keq_pkg::CodeWidth + 1)'(KEY_COUNT);
  localparam logic [KW-1:0] LastKey = KW'(KEY_COUNT - 1);
  localparam logic [QW-1:0] LastSlot = QW'(QUEUE_DEPTH - 1);

  keq_pkg::in_item_t req;
  logic [keq_pkg::TimeoutWidth-1:0] timeout;

  logic [keq_pkg::TimeWidth-1:0]  last_seen [KEY_COUNT];
  logic [keq_pkg::EventWidth-1:0] event_store [QUEUE_DEPTH];
  logic [KEY_COUNT-1:0]           held;

  logic [KW-1:0]                  scan_idx;
  logic [KW-1:0]                  eval_idx;
  logic                           eval_valid;
  logic [keq_pkg::TimeWidth-1:0]  seen_q;

  logic [QW-1:0]                  wr_ptr;
  logic [QW-1:0]                  rd_ptr;
  logic [QW-1:0]                  wr_ptr_next;
  logic [QW-1:0]                  rd_ptr_next;
  logic [keq_pkg::EventWidth-1:0] pop_data;
  logic                           empty_q;

  logic                           key_ok;
  logic [KW-1:0]                  key_idx;
  logic [keq_pkg::TimeWidth-1:0]  idle_time;
  logic                           release_hit;
  logic                           push_en;
  logic [keq_pkg::EventWidth-1:0] push_data;

  assign key_ok  = (req.key_code != '0) && ({1'b0, req.key_code} < KeyLimit);
  assign key_idx = req.key_code[KW-1:0];

  // Idle time wraps modulo 2^32; equal to the timeout still counts as held.
  assign idle_time   = req.now_ms - seen_q;
  assign release_hit = eval_valid && held[eval_idx] &&
                       (idle_time > {{(keq_pkg::TimeWidth - keq_pkg::TimeoutWidth){1'b0}},
                                     timeout});

  assign wr_ptr_next = (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;

  always_comb begin
    push_en   = 1'b0;
    push_data = '0;
    if (ctrl.arrive && key_ok) begin
      push_en   = 1'b1;
      push_data = {1'b1, req.key_code};
    end else if (release_hit) begin
      push_en   = 1'b1;
      push_data = {1'b0, keq_pkg::CodeWidth'(eval_idx)};
    end
  end

  assign status.scan_last = (scan_idx == LastKey);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= keq_pkg::TimeoutReset;
    end else if (cfg_we) begin
      timeout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req <= request;
    end
  end

  // Scan pipeline: read a key's last-seen time, evaluate it in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      eval_valid <= 1'b0;
    end else begin
      eval_valid <= ctrl.scan_step;
      if (ctrl.load) begin
        scan_idx <= '0;
      end else if (ctrl.scan_step && !status.scan_last) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (ctrl.arrive && key_ok) begin
      last_seen[key_idx] <= req.now_ms;
    end
    if (ctrl.scan_step) begin
      seen_q <= last_seen[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      if (ctrl.arrive && key_ok) begin
        held[key_idx] <= 1'b1;
      end
      if (release_hit) begin
        held[eval_idx] <= 1'b0;
      end
    end
  end

  // Event ring; one slot stays free so that full and empty differ.
  always_ff @(posedge clk) begin
    if (push_en && (wr_ptr_next != rd_ptr)) begin
      event_store[wr_ptr] <= push_data;
    end
    if (ctrl.pop_read) begin
      pop_data <= event_store[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push_en && (wr_ptr_next != rd_ptr)) begin
        wr_ptr <= wr_ptr_next;
      end
      if (ctrl.pop_emit && !empty_q) begin
        rd_ptr <= rd_ptr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop_read) begin
      empty_q <= (rd_ptr == wr_ptr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.pop_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop_emit) begin
      result.has_event <= !empty_q;
      result.is_press  <= empty_q ? 1'b0 : pop_data[keq_pkg::CodeWidth];
      result.event_key <= empty_q ? '0 : pop_data[keq_pkg::CodeWidth-1:0];
    end
  end

endmodule
